FILE: src/ffd_pkg.sv
package ffd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned KeyLenW     = 4;
  localparam int unsigned KindW       = 2;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned MaxKeyChars = 8;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [CfgIdxW-1:0] CfgKeyBytes  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyLength = 1'b1;

  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChPct   = 8'h25;
  localparam logic [ByteW-1:0] ChAmp   = 8'h26;
  localparam logic [ByteW-1:0] ChEq    = 8'h3D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;

  typedef enum logic [KindW-1:0] {
    KindData = 2'd0,
    KindEnd  = 2'd1,
    KindNone = 2'd2,
    KindBad  = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    PhSearch = 6'b000001,
    PhSkip   = 6'b000010,
    PhValue  = 6'b000100,
    PhEsc1   = 6'b001000,
    PhEsc2   = 6'b010000,
    PhDone   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } push_t;

  localparam result_t ResultZero = '{data: '0, kind: KindData, last: 1'b0};

  // Bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_val(input logic [ByteW-1:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end
    return v;
  endfunction

endpackage

FILE: src/ffd_in_if.sv
interface ffd_in_if;
  import ffd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             in_last;
  modport source(output valid, output in_byte, output in_last, input ready);
  modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

FILE: src/ffd_out_if.sv
interface ffd_out_if;
  import ffd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic [KindW-1:0] out_kind;
  logic             out_last;
  modport source(output valid, output out_byte, output out_kind, output out_last, input ready);
  modport sink(input valid, input out_byte, input out_kind, input out_last, output ready);
endinterface

FILE: src/ffd_core.sv
module ffd_core #(
  parameter int unsigned MAX_KEY_CHARS = ffd_pkg::MaxKeyChars
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ffd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ffd_pkg::KeyW-1:0]     cfg_data_i,
  ffd_in_if.sink                       in_i,
  input  logic                         room_i,
  output ffd_pkg::push_t               push_o
);
  import ffd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_KEY_CHARS + 1);

  logic [KeyW-1:0]    key_q;
  logic [KeyLenW-1:0] key_len_q;

  logic               stg_vld_q;
  logic [ByteW-1:0]   stg_byte_q;
  logic               stg_last_q;

  phase_e             phase_q, phase_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [3:0]         nib_q, nib_d;

  logic               advance;
  logic [KeyLenW-1:0] len_clamp;
  logic [CntW-1:0]    len;
  logic [ByteW-1:0]   key_char;
  logic [4:0]         hex;
  logic               status;
  logic               has_a, has_t;
  result_t            res_a, res_t;

  assign advance   = stg_vld_q & room_i;
  assign in_i.ready = ~stg_vld_q | room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= KeyLenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKeyBytes:  key_q     <= cfg_data_i;
        CfgKeyLength: key_len_q <= cfg_data_i[KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_clamp = key_len_q;
    if (key_len_q == '0) begin
      len_clamp = KeyLenW'(1);
    end else if (key_len_q > KeyLenW'(MAX_KEY_CHARS)) begin
      len_clamp = KeyLenW'(MAX_KEY_CHARS);
    end
  end
  assign len = CntW'(len_clamp);

  always_comb begin
    key_char = '0;
    for (int i = 0; i < MAX_KEY_CHARS; i++) begin
      if (cnt_q == CntW'(i)) begin
        key_char = key_q[i*ByteW +: ByteW];
      end
    end
  end

  assign hex = hex_val(stg_byte_q);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    nib_d   = nib_q;
    status  = 1'b0;
    has_a   = 1'b0;
    has_t   = 1'b0;
    res_a   = ResultZero;
    res_t   = ResultZero;
    unique case (phase_q)
      PhSearch: begin
        if (stg_byte_q == ChAmp) begin
          cnt_d = '0;
        end else if (cnt_q >= len) begin
          phase_d = (stg_byte_q == ChEq) ? PhValue : PhSkip;
        end else if (stg_byte_q == key_char) begin
          cnt_d = cnt_q + CntW'(1);
        end else begin
          phase_d = PhSkip;
        end
      end
      PhSkip: begin
        if (stg_byte_q == ChAmp) begin
          phase_d = PhSearch;
          cnt_d   = '0;
        end
      end
      PhValue: begin
        if (stg_byte_q == ChPlus) begin
          has_a      = 1'b1;
          res_a.data = ChSpace;
        end else if (stg_byte_q == ChPct) begin
          phase_d = PhEsc1;
        end else if (stg_byte_q == ChAmp) begin
          has_a      = 1'b1;
          res_a.kind = KindEnd;
          res_a.last = stg_last_q;
          status     = 1'b1;
          phase_d    = PhDone;
        end else begin
          has_a      = 1'b1;
          res_a.data = stg_byte_q;
        end
      end
      PhEsc1: begin
        if (!hex[4]) begin
          nib_d   = hex[3:0];
          phase_d = PhEsc2;
        end else begin
          has_a      = 1'b1;
          res_a.kind = KindBad;
          res_a.last = stg_last_q;
          status     = 1'b1;
          phase_d    = PhDone;
        end
      end
      PhEsc2: begin
        has_a = 1'b1;
        if (!hex[4]) begin
          res_a.data = {nib_q, hex[3:0]};
          phase_d    = PhValue;
        end else begin
          res_a.kind = KindBad;
          res_a.last = stg_last_q;
          status     = 1'b1;
          phase_d    = PhDone;
        end
      end
      PhDone: ;
      default: ;
    endcase
    if (stg_last_q) begin
      if (!status) begin
        res_t.last = 1'b1;
        unique case (phase_d)
          PhSearch, PhSkip: begin
            has_t      = 1'b1;
            res_t.kind = KindNone;
          end
          PhValue: begin
            has_t      = 1'b1;
            res_t.kind = KindEnd;
          end
          PhEsc1, PhEsc2: begin
            has_t      = 1'b1;
            res_t.kind = KindBad;
          end
          default: ;
        endcase
      end
      phase_d = PhSearch;
      cnt_d   = '0;
      nib_d   = '0;
    end
  end

  always_comb begin
    push_o.n    = '0;
    push_o.res0 = has_a ? res_a : res_t;
    push_o.res1 = res_t;
    if (advance) begin
      push_o.n = 2'(has_a) + 2'(has_t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stg_byte_q <= in_i.in_byte;
      stg_last_q <= in_i.in_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSearch;
      cnt_q   <= '0;
      nib_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      nib_q   <= nib_d;
    end
  end

`ifndef SYNTHESIS
  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n == 2'd2 |-> push_o.res0.kind == KindData && push_o.res1.last)
    else $error("two results without a trailing status");
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && stg_last_q |=> phase_q == PhSearch && cnt_q == '0 && nib_q == '0)
    else $error("state not cleared after final byte");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room_i |-> push_o.n == 2'd0)
    else $error("push without queue room");
  a_match_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_KEY_CHARS))
    else $error("match count past key length");
`endif

endmodule

FILE: src/ffd_out_queue.sv
module ffd_out_queue #(
  parameter int unsigned DEPTH = ffd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ffd_pkg::push_t push_i,
  output logic           room_o,
  ffd_out_if.source      out_o
);
  import ffd_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  result_t         mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q, wptr_nx;
  logic [CntW-1:0] count_q;
  logic            pop;
  result_t         head;

  assign wptr_nx = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
  assign room_o  = count_q <= CntW'(DEPTH - 2);
  assign pop     = out_o.valid & out_o.ready;
  assign head    = mem_q[rptr_q];

  assign out_o.valid    = count_q != '0;
  assign out_o.out_byte = head.data;
  assign out_o.out_kind = head.kind;
  assign out_o.out_last = head.last;

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wptr_q] <= push_i.res0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wptr_nx] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i.n == 2'd1) begin
        wptr_q <= wptr_nx;
      end else if (push_i.n == 2'd2) begin
        wptr_q <= (wptr_nx == PtrW'(DEPTH - 1)) ? '0 : wptr_nx + PtrW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i.n) - CntW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> room_o)
    else $error("push into full queue");
  a_pair_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n == 2'd2 && count_q == '0 |=> count_q == CntW'(2))
    else $error("paired push lost");
`endif

endmodule

FILE: src/form_field_extract_decode.sv
// Form field extractor with percent decoding.
// Input channel in_i: one raw byte of a url-encoded parameter string per beat,
// in_last on the final byte. Configuration: cfg_we_i writes cfg_data_i into
// register cfg_idx_i (0 key bytes, first character in the low byte; 1 key
// length) and must only be used while no string is in flight.
// Output channel out_o: one result per beat: decoded data bytes, then one
// status (value ended, key not found, bad escape) with out_kind. out_last
// marks the result produced on the final input byte.
// A byte is registered in a staging register, decoded from there and written into a
// result queue of QUEUE_DEPTH entries (four by default) once it has room; its first
// result then appears at the queue head. Throughput: one input byte per cycle while
// the queue has room; the queue absorbs the extra status on the last byte.
// When the receiver stalls the queue fills and, with a byte staged, in_i.ready
// drops once fewer than two entries are free; nothing is lost.
// Reset empties the queue, returns the search to the start of a segment and
// sets the key to zero with length one.
module form_field_extract_decode #(
  parameter int unsigned MAX_KEY_CHARS = ffd_pkg::MaxKeyChars,
  parameter int unsigned QUEUE_DEPTH   = ffd_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ffd_pkg::KeyW-1:0]    cfg_data_i,
  ffd_in_if.sink                      in_i,
  ffd_out_if.source                   out_o
);
  import ffd_pkg::*;

  push_t push;
  logic  room;

  ffd_core #(
    .MAX_KEY_CHARS(MAX_KEY_CHARS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .room_i     (room),
    .push_o     (push)
  );

  ffd_out_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
